// ===== rtl/core/rlp_pkg.sv =====
// Shared types, codes and constants for the RLP field encoder.
// Used by every module under rtl/core; no dependencies.
package rlp_pkg;

  localparam int unsigned LEN_W          = 32;
  localparam int unsigned LEN_BYTES_W    = LEN_W / 8;
  localparam int unsigned CNT_W          = $clog2(LEN_BYTES_W + 1);
  localparam int unsigned LENGTH_BYTES   = 4;
  localparam int unsigned SHORT_MAX      = 55;
  localparam logic [7:0]  STR_BASE       = 8'h80;
  localparam logic [7:0]  LIST_BASE      = 8'hC0;
  localparam logic [7:0]  SINGLE_MAX     = 8'h7f;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 32'h0001_0000;

  typedef enum logic {
    OP_BEGIN   = 1'b0,
    OP_PAYLOAD = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_LONG = 2'd1,
    STATUS_STRAY    = 2'd2
  } status_e;

  typedef struct packed {
    op_e              operation;
    logic [LEN_W-1:0] field_length;
    logic             is_list;
    logic             header_only;
    logic [7:0]       first_byte;
    logic [7:0]       payload_byte;
  } item_t;

  // One run of result words: a head word, then len_cnt length bytes taken
  // from the top of len_sh.
  typedef struct packed {
    logic [7:0]       head;
    logic             is_header;
    status_e          status;
    logic [CNT_W-1:0] len_cnt;
    logic [LEN_W-1:0] len_sh;
  } run_t;

  // Number of significant bytes in a length word.
  function automatic logic [CNT_W-1:0] sig_bytes(input logic [LEN_W-1:0] len);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < LEN_BYTES_W; i++) begin
      if (|len[i*8 +: 8]) begin
        n = CNT_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/rlp_in_reg.sv =====
// Input register stage of the RLP field encoder.
// Depends on rlp_pkg for the input word type.
module rlp_in_reg
  import rlp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  take_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/core/rlp_decoder.sv =====
// Field state, max_length register and per-word decode into a result run.
// Depends on rlp_pkg.
module rlp_decoder
  import rlp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [LEN_W-1:0] cfg_data_i,
  input  logic             valid_i,
  input  item_t            item_i,
  input  logic             load_ok_i,
  output logic             take_o,
  output logic             run_valid_o,
  output run_t             run_o
);

  logic [LEN_W-1:0] max_len_q;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             pass_q, pass_d;
  logic             has_res;
  logic [CNT_W-1:0] nb;
  logic [CNT_W-1:0] sh_bytes;
  logic             too_long;
  logic             single;
  logic [7:0]       base;
  logic [LEN_W-1:0] len;

  assign len      = item_i.field_length;
  assign nb       = sig_bytes(len);
  assign sh_bytes = CNT_W'(LEN_BYTES_W) - nb;
  assign too_long = (len > max_len_q) || ((len > SHORT_MAX) && (nb > CNT_W'(LENGTH_BYTES)));
  assign single   = !item_i.is_list && (len == LEN_W'(1)) && (item_i.first_byte <= SINGLE_MAX);
  assign base     = item_i.is_list ? LIST_BASE : STR_BASE;

  always_comb begin
    has_res         = 1'b1;
    run_o.head      = 8'h00;
    run_o.is_header = 1'b0;
    run_o.status    = STATUS_OK;
    run_o.len_cnt   = '0;
    run_o.len_sh    = '0;
    rem_d           = rem_q;
    pass_d          = pass_q;
    if (item_i.operation == OP_PAYLOAD) begin
      if (!pass_q || rem_q == '0) begin
        run_o.status = STATUS_STRAY;
      end else begin
        run_o.head = item_i.payload_byte;
        rem_d      = rem_q - LEN_W'(1);
        if (rem_q == LEN_W'(1)) begin
          pass_d = 1'b0;
        end
      end
    end else begin
      rem_d  = '0;
      pass_d = 1'b0;
      if (too_long) begin
        run_o.status = STATUS_TOO_LONG;
      end else begin
        if (!item_i.header_only && len != '0) begin
          rem_d  = len;
          pass_d = 1'b1;
        end
        if (single) begin
          has_res = 1'b0;
        end else if (len <= SHORT_MAX) begin
          run_o.head      = base + len[7:0];
          run_o.is_header = 1'b1;
        end else begin
          run_o.head      = base + 8'(SHORT_MAX) + 8'(nb);
          run_o.is_header = 1'b1;
          run_o.len_cnt   = nb;
          run_o.len_sh    = len << {sh_bytes, 3'b000};
        end
      end
    end
  end

  assign take_o      = valid_i && (!has_res || load_ok_i);
  assign run_valid_o = valid_i && has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LENGTH_RST;
      rem_q     <= '0;
      pass_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_len_q <= cfg_data_i;
      end
      if (take_o) begin
        rem_q  <= rem_d;
        pass_q <= pass_d;
      end
    end
  end

endmodule

// ===== rtl/core/rlp_serializer.sv =====
// Result register: sends a run of result words, one per cycle while out_ready_i is high.
// Depends on rlp_pkg.
module rlp_serializer
  import rlp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       run_valid_i,
  input  run_t       run_i,
  output logic       load_ok_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_header_o,
  output logic       last_of_run_o,
  output logic [1:0] status_o
);

  logic             valid_q;
  logic [CNT_W-1:0] cnt_q;
  logic [7:0]       byte_q;
  logic             hdr_q;
  status_e          status_q;
  logic [LEN_W-1:0] sh_q;
  logic             last;
  logic             advance;
  logic             load;

  assign last      = (cnt_q == '0);
  assign load_ok_o = !valid_q || (out_ready_i && last);
  assign advance   = valid_q && out_ready_i && !last;
  assign load      = load_ok_o && run_valid_i;

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign is_header_o   = hdr_q;
  assign last_of_run_o = last;
  assign status_o      = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (load_ok_o) begin
        valid_q <= run_valid_i;
      end
      if (load) begin
        cnt_q <= run_i.len_cnt;
      end else if (advance) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= run_i.head;
      hdr_q    <= run_i.is_header;
      status_q <= run_i.status;
      sh_q     <= run_i.len_sh;
    end else if (advance) begin
      byte_q <= sh_q[LEN_W-1 -: 8];
      sh_q   <= sh_q << 8;
    end
  end

endmodule

// ===== rtl/core/rlp_field_encoder.sv =====
// RLP field encoder: one input word per cycle unless the output holds it, one
// encoded byte per cycle out while out_ready_i is high. Each word is held in
// an input register, decoded, and its results leave from an output register.
// Begin words give a single prefix byte, or for lengths above 55 a prefix and
// one to four length bytes; payload words and errors give one byte. A long
// header holds the input until its length bytes are sent; a one-byte string
// of value at most 0x7f gives no header and costs nothing at the output.
// max_length is written through the cfg channel, which is always ready.
// Depends on rlp_pkg, rlp_in_reg, rlp_decoder, rlp_serializer.
module rlp_field_encoder
  import rlp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             operation_i,
  input  logic [LEN_W-1:0] field_length_i,
  input  logic             is_list_i,
  input  logic             header_only_i,
  input  logic [7:0]       first_byte_i,
  input  logic [7:0]       payload_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             is_header_o,
  output logic             last_of_run_o,
  output logic [1:0]       status_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LEN_W-1:0] max_length_i
);

  item_t item_in;
  item_t item_q;
  logic  item_valid;
  logic  take;
  logic  run_valid;
  run_t  run;
  logic  load_ok;

  assign cfg_ready_o = 1'b1;

  assign item_in.operation    = op_e'(operation_i);
  assign item_in.field_length = field_length_i;
  assign item_in.is_list      = is_list_i;
  assign item_in.header_only  = header_only_i;
  assign item_in.first_byte   = first_byte_i;
  assign item_in.payload_byte = payload_byte_i;

  rlp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .take_i     (take),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  rlp_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (max_length_i),
    .valid_i     (item_valid),
    .item_i      (item_q),
    .load_ok_i   (load_ok),
    .take_o      (take),
    .run_valid_o (run_valid),
    .run_o       (run)
  );

  rlp_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .run_valid_i   (run_valid),
    .run_i         (run),
    .load_ok_o     (load_ok),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .is_header_o   (is_header_o),
    .last_of_run_o (last_of_run_o),
    .status_o      (status_o)
  );

endmodule

// ===== tb/tb_rlp_field_encoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rlp_field_encoder: directed table, then random fields.
// Holds its own byte-level encoder model; depends on rlp_pkg and the rtl/core sources.
module tb_rlp_field_encoder;
  import rlp_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_TAIL = 12;
  localparam int RAND_WORDS = 476;
  localparam int NUM_PHASES = 7;

  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       last;
    status_e    status;
  } enc_byte_t;

  typedef enum logic {
    ROW_WORD = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    item_t      it;
    logic       typed;
    logic [7:0] t_byte;
    logic       t_hdr;
    status_e    t_status;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             operation_i;
  logic [LEN_W-1:0] field_length_i;
  logic             is_list_i;
  logic             header_only_i;
  logic [7:0]       first_byte_i;
  logic [7:0]       payload_byte_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [7:0]       out_byte_o;
  logic             is_header_o;
  logic             last_of_run_o;
  logic [1:0]       status_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [LEN_W-1:0] max_length_i;

  rlp_field_encoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .field_length_i (field_length_i),
    .is_list_i      (is_list_i),
    .header_only_i  (header_only_i),
    .first_byte_i   (first_byte_i),
    .payload_byte_i (payload_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .is_header_o    (is_header_o),
    .last_of_run_o  (last_of_run_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .max_length_i   (max_length_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // model state
  logic [LEN_W-1:0] max_len_q;
  logic [LEN_W-1:0] open_left;
  logic             open_pass;
  enc_byte_t        enc_buf [5];
  enc_byte_t        pending_bytes_q [$];

  int errors      = 0;
  int words_in    = 0;
  int words_out   = 0;
  int cfg_writes  = 0;
  int burst_left  = 0;
  int idle_cnt    = 0;
  int rx_cyc      = 0;
  int rx_mode     = 0;
  int rx_left     = 0;

  function automatic enc_byte_t mk_byte(logic [7:0] d, logic h, logic l, status_e s);
    enc_byte_t b;
    b.data   = d;
    b.hdr    = h;
    b.last   = l;
    b.status = s;
    return b;
  endfunction

  // Returns the number of result words for one input word, fills enc_buf.
  function automatic int encode_item(input item_t it);
    logic [LEN_W-1:0] t;
    logic [7:0]       base;
    int               nb;
    if (it.operation == OP_PAYLOAD) begin
      if (!open_pass || open_left == '0) begin
        enc_buf[0] = mk_byte(8'h00, 1'b0, 1'b1, STATUS_STRAY);
        return 1;
      end
      open_left = open_left - 1;
      if (open_left == '0) open_pass = 1'b0;
      enc_buf[0] = mk_byte(it.payload_byte, 1'b0, 1'b1, STATUS_OK);
      return 1;
    end
    open_left = '0;
    open_pass = 1'b0;
    nb = 0;
    t  = it.field_length;
    while (t != '0) begin
      nb++;
      t = t >> 8;
    end
    if (it.field_length > max_len_q ||
        (it.field_length > SHORT_MAX && nb > LENGTH_BYTES)) begin
      enc_buf[0] = mk_byte(8'h00, 1'b0, 1'b1, STATUS_TOO_LONG);
      return 1;
    end
    if (!it.header_only && it.field_length != '0) begin
      open_left = it.field_length;
      open_pass = 1'b1;
    end
    if (!it.is_list && it.field_length == 1 && it.first_byte <= SINGLE_MAX) return 0;
    base = it.is_list ? LIST_BASE : STR_BASE;
    if (it.field_length <= SHORT_MAX) begin
      enc_buf[0] = mk_byte(base + it.field_length[7:0], 1'b1, 1'b1, STATUS_OK);
      return 1;
    end
    enc_buf[0] = mk_byte(base + 8'(SHORT_MAX) + 8'(nb), 1'b1, 1'b0, STATUS_OK);
    for (int k = 0; k < nb; k++) begin
      enc_buf[k+1] = mk_byte(8'(it.field_length >> (8 * (nb - 1 - k))), 1'b1,
                             (k == nb - 1), STATUS_OK);
    end
    return nb + 1;
  endfunction

  function automatic item_t rand_item(op_e op);
    item_t it;
    it.operation    = op;
    it.field_length = $urandom;
    it.is_list      = $urandom_range(0, 1);
    it.header_only  = $urandom_range(0, 1);
    it.first_byte   = $urandom_range(0, 255);
    it.payload_byte = $urandom_range(0, 255);
    return it;
  endfunction

  function automatic row_t begin_row(logic [LEN_W-1:0] len, logic list, logic ho,
                                     logic [7:0] first);
    row_t r;
    r = '0;
    r.kind            = ROW_WORD;
    r.it.operation    = OP_BEGIN;
    r.it.field_length = len;
    r.it.is_list      = list;
    r.it.header_only  = ho;
    r.it.first_byte   = first;
    return r;
  endfunction

  function automatic row_t pay_row(logic [7:0] b);
    row_t r;
    r = '0;
    r.kind            = ROW_WORD;
    r.it.operation    = OP_PAYLOAD;
    r.it.payload_byte = b;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [LEN_W-1:0] v);
    row_t r;
    r = '0;
    r.kind            = ROW_CFG;
    r.it.field_length = v;
    return r;
  endfunction

  function automatic row_t typed_row(row_t r, logic [7:0] b, logic h, status_e s);
    r.typed    = 1'b1;
    r.t_byte   = b;
    r.t_hdr    = h;
    r.t_status = s;
    return r;
  endfunction

  task automatic send_word(input item_t it, input logic typed, input enc_byte_t t_res);
    int n;
    in_valid_i     <= 1'b1;
    operation_i    <= it.operation;
    field_length_i <= it.field_length;
    is_list_i      <= it.is_list;
    header_only_i  <= it.header_only;
    first_byte_i   <= it.first_byte;
    payload_byte_i <= it.payload_byte;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n = encode_item(it);
    if (typed) begin
      pending_bytes_q.push_back(t_res);
    end else begin
      for (int k = 0; k < n; k++) pending_bytes_q.push_back(enc_buf[k]);
    end
    words_in++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      if ($urandom_range(0, 4) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  // wait for every pending result, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic write_max_length(input logic [LEN_W-1:0] v);
    drain();
    cfg_valid_i  <= 1'b1;
    max_length_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    max_len_q = v;
    cfg_writes++;
  endtask

  task automatic send_field();
    item_t            it;
    logic [LEN_W-1:0] len;
    logic             ho;
    int               n_pay;
    int               sel;
    if ($urandom_range(0, 9) == 0) begin
      send_word(rand_item(OP_PAYLOAD), 1'b0, '0);
      return;
    end
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: len = $urandom_range(0, 8);
      3, 4:    len = $urandom_range(0, 55);
      5:       len = $urandom_range(56, 64);
      6:       len = $urandom_range(56, 70000);
      7:       len = $urandom;
      8:       len = max_len_q + $urandom_range(0, 2) - 1;
      default: len = 1;
    endcase
    if (len > 64) ho = ($urandom_range(0, 4) != 0);
    else          ho = ($urandom_range(0, 4) == 0);
    it              = rand_item(OP_BEGIN);
    it.field_length = len;
    it.header_only  = ho;
    send_word(it, 1'b0, '0);
    if (ho)             n_pay = ($urandom_range(0, 9) == 0);
    else if (len > 64)  n_pay = $urandom_range(0, 8);
    else begin
      n_pay = int'(len);
      sel   = $urandom_range(0, 19);
      if (sel < 2)       n_pay = $urandom_range(0, n_pay);
      else if (sel == 2) n_pay++;
    end
    repeat (n_pay) send_word(rand_item(OP_PAYLOAD), 1'b0, '0);
  endtask

  // receiver: checks each word and stalls on its own pattern
  always @(posedge clk_i) begin : rx_side
    enc_byte_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        words_out++;
        if (pending_bytes_q.size() == 0) begin
          $error("unexpected word: out_byte %0h status %0d", out_byte_o, status_o);
          errors++;
        end else begin
          e = pending_bytes_q.pop_front();
          if (out_byte_o !== e.data) begin
            $error("out_byte: expected %0h, got %0h", e.data, out_byte_o);
            errors++;
          end
          if (is_header_o !== e.hdr) begin
            $error("is_header: expected %0b, got %0b", e.hdr, is_header_o);
            errors++;
          end
          if (last_of_run_o !== e.last) begin
            $error("last_of_run: expected %0b, got %0b", e.last, last_of_run_o);
            errors++;
          end
          if (status_o !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_o);
            errors++;
          end
        end
      end
      rx_cyc++;
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(32, 256);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= $urandom_range(0, 1);
        2:       out_ready_i <= ((rx_cyc % 7) < 4);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cnt <= 0;
      end else if (idle_cnt >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  initial begin : main
    row_t             rows [$];
    row_t             r;
    logic [LEN_W-1:0] phase_max;
    int               goal;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    operation_i    <= OP_BEGIN;
    field_length_i <= '0;
    is_list_i      <= 1'b0;
    header_only_i  <= 1'b0;
    first_byte_i   <= 8'h00;
    payload_byte_i <= 8'h00;
    out_ready_i    <= 1'b0;
    cfg_valid_i    <= 1'b0;
    max_length_i   <= '0;
    max_len_q = MAX_LENGTH_RST;
    open_left = '0;
    open_pass = 1'b0;

    rows.push_back(typed_row(pay_row(8'h5A), 8'h00, 1'b0, STATUS_STRAY));
    rows.push_back(typed_row(begin_row(0, 1'b0, 1'b0, 8'h00), STR_BASE, 1'b1, STATUS_OK));
    rows.push_back(typed_row(begin_row(0, 1'b1, 1'b0, 8'h00), LIST_BASE, 1'b1, STATUS_OK));
    rows.push_back(begin_row(1, 1'b0, 1'b0, 8'h7F));
    rows.push_back(pay_row(8'h7F));
    rows.push_back(begin_row(1, 1'b0, 1'b0, 8'h80));
    rows.push_back(pay_row(8'h80));
    rows.push_back(begin_row(1, 1'b0, 1'b1, 8'h00));
    rows.push_back(typed_row(pay_row(8'h55), 8'h00, 1'b0, STATUS_STRAY));
    rows.push_back(begin_row(1, 1'b1, 1'b0, 8'h00));
    rows.push_back(pay_row(8'h00));
    rows.push_back(typed_row(begin_row(55, 1'b0, 1'b1, 8'hFF), 8'hB7, 1'b1, STATUS_OK));
    rows.push_back(typed_row(begin_row(55, 1'b1, 1'b1, 8'hFF), 8'hF7, 1'b1, STATUS_OK));
    rows.push_back(begin_row(56, 1'b0, 1'b1, 8'h00));
    rows.push_back(begin_row(MAX_LENGTH_RST, 1'b1, 1'b1, 8'h00));
    rows.push_back(typed_row(begin_row(MAX_LENGTH_RST + 1, 1'b0, 1'b0, 8'h00),
                             8'h00, 1'b0, STATUS_TOO_LONG));
    rows.push_back(begin_row(3, 1'b0, 1'b0, 8'hAA));
    rows.push_back(pay_row(8'h01));
    rows.push_back(begin_row(2, 1'b1, 1'b0, 8'h00));
    rows.push_back(pay_row(8'hFF));
    rows.push_back(pay_row(8'hFF));
    rows.push_back(typed_row(pay_row(8'h00), 8'h00, 1'b0, STATUS_STRAY));
    rows.push_back(cfg_row(32'h0000_0000));
    rows.push_back(typed_row(begin_row(0, 1'b0, 1'b0, 8'h00), STR_BASE, 1'b1, STATUS_OK));
    rows.push_back(typed_row(begin_row(1, 1'b1, 1'b0, 8'h00), 8'h00, 1'b0, STATUS_TOO_LONG));
    rows.push_back(cfg_row(32'hFFFF_FFFF));
    rows.push_back(begin_row(32'hFFFF_FFFF, 1'b0, 1'b1, 8'h00));
    rows.push_back(begin_row(32'h0100_0000, 1'b1, 1'b1, 8'h00));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      r = rows[i];
      if (r.kind == ROW_CFG) begin
        write_max_length(r.it.field_length);
      end else begin
        send_word(r.it, r.typed, mk_byte(r.t_byte, r.t_hdr, 1'b1, r.t_status));
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       phase_max = 32'hFFFF_FFFF;
        1:       phase_max = 55;
        2:       phase_max = 56;
        3:       phase_max = 256;
        4:       phase_max = 0;
        5:       phase_max = $urandom_range(0, 300);
        default: phase_max = $urandom;
      endcase
      write_max_length(phase_max);
      goal = words_in + RAND_WORDS / NUM_PHASES;
      while (words_in < goal) begin
        send_field();
        if ($urandom_range(0, 49) == 0) drain();
      end
    end

    drain();
    $display("summary: %0d input words, %0d output words checked, %0d max_length writes",
             words_in, words_out, cfg_writes);
    if (errors == 0 && pending_bytes_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rlp_pkg.sv
rtl/core/rlp_in_reg.sv
rtl/core/rlp_decoder.sv
rtl/core/rlp_serializer.sv
rtl/core/rlp_field_encoder.sv
tb/tb_rlp_field_encoder.sv
